// ===== hdl/sssd_pkg.sv =====
// Shared types, constants and the segment font for the seven-segment scan driver.
// No dependencies.
`timescale 1ns / 1ps

package sssd_pkg;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	localparam logic [15:0] LOAD_LIMIT   = 16'd10000;
	localparam logic [15:0] PERIOD_RESET = 16'd5;

	// Reciprocals for exact division of values below 10000
	localparam logic [15:0] RECIP10   = 16'd52429; // >> 19
	localparam logic [12:0] RECIP100  = 13'd5243;  // >> 19
	localparam logic [13:0] RECIP1000 = 14'd8389;  // >> 23

	// Quotients of one load value, v/10, v/100, v/1000
	typedef struct packed {
		logic       in_range;
		logic [9:0] q10;
		logic [6:0] q100;
		logic [3:0] q1000;
	} quot_t;

	// Bit0 = a .. bit6 = g, bit7 = dp (never lit); non-decimal codes dark
	function automatic logic [7:0] seg_font(input logic [3:0] code);
		logic [7:0] seg;
		case (code)
			4'd0:    seg = 8'h3F;
			4'd1:    seg = 8'h06;
			4'd2:    seg = 8'h5B;
			4'd3:    seg = 8'h4F;
			4'd4:    seg = 8'h66;
			4'd5:    seg = 8'h6D;
			4'd6:    seg = 8'h7D;
			4'd7:    seg = 8'h07;
			4'd8:    seg = 8'h7F;
			4'd9:    seg = 8'h6F;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

endpackage

// ===== hdl/seven_segment_scan_driver_top.sv =====
// Top level of the four-digit multiplexed seven-segment scan driver.
// Depends on sssd_pkg and sssd_bcd_split.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   input    | in_valid / in_ready  | opcode, value
//   output   | out_valid / out_ready| segments, digit_select, scanned
//   config   | cfg_we (no wait)     | cfg_wdata -> refresh_period
//
// One item per cycle sustained while the output is not stalled; the result
// passes the input register (with decimal quotients), then the result register.
// State (prescaler, digits, scan index, latches) updates as an item moves
// from the input register into the result register.
// A stalled output holds the result register; the input register still
// takes a new item in the cycle the result is taken.
// Reset clears all control state; refresh_period resets to 5.
`timescale 1ns / 1ps

module seven_segment_scan_driver_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [15:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  segments,
	output logic [3:0]  digit_select,
	output logic        scanned,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	// low 4 bits of 10*q, enough since the remainder is a decimal digit
	function automatic logic [3:0] times10_lo(input logic [3:0] q);
		return {q[0], 3'b000} + {q[2:0], 1'b0};
	endfunction

	// ---------------- input register ----------------
	sssd_pkg::quot_t quot_in;
	logic            valid_s1;
	sssd_pkg::op_t   op_s1;
	logic [3:0]      xlo_s1;   // low nibble of the value, for the ones digit
	sssd_pkg::quot_t quot_s1;
	logic            advance;

	sssd_bcd_split u_split (
		.value (value),
		.quot  (quot_in)
	);

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= sssd_pkg::op_t'(opcode);
			xlo_s1  <= value[3:0];
			quot_s1 <= quot_in;
		end
	end

	// ---------------- block state ----------------
	logic [15:0] refresh_period_q;
	logic [15:0] tick_count_q;
	logic [3:0]  digit_q [4];
	logic [1:0]  scan_index_q;
	logic [7:0]  seg_latch_q;
	logic [3:0]  sel_latch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_period_q <= sssd_pkg::PERIOD_RESET;
		end else if (cfg_we) begin
			refresh_period_q <= cfg_wdata;
		end
	end

	// digits from the registered quotients
	logic [3:0] new_digit [4];
	assign new_digit[0] = xlo_s1 - times10_lo(quot_s1.q10[3:0]);
	assign new_digit[1] = quot_s1.q10[3:0] - times10_lo(quot_s1.q100[3:0]);
	assign new_digit[2] = quot_s1.q100[3:0] - times10_lo(quot_s1.q1000);
	assign new_digit[3] = quot_s1.q1000;

	logic [15:0] tick_next;
	logic        do_scan;
	logic [1:0]  idx;
	logic [7:0]  seg_next;
	logic [3:0]  sel_next;

	assign tick_next = tick_count_q + 16'd1;
	assign do_scan   = (op_s1 == sssd_pkg::OP_TICK) && (tick_next == refresh_period_q);

	// leading-zero narrowing; the ones digit always stays in range
	always_comb begin
		idx = scan_index_q;
		if (digit_q[3] == 4'd0 && digit_q[2] == 4'd0 && digit_q[1] == 4'd0) begin
			idx = 2'd0;
		end else if (digit_q[3] == 4'd0 && digit_q[2] == 4'd0) begin
			idx = {1'b0, scan_index_q[0]};
		end else if (digit_q[3] == 4'd0) begin
			idx = (scan_index_q == 2'd3) ? 2'd0 : scan_index_q;
		end
	end

	assign seg_next = do_scan ? sssd_pkg::seg_font(digit_q[idx]) : seg_latch_q;
	assign sel_next = do_scan ? (4'b0001 << idx) : sel_latch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			scan_index_q <= '0;
			seg_latch_q  <= '0;
			sel_latch_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				digit_q[i] <= '0;
			end
		end else if (advance) begin
			if (op_s1 == sssd_pkg::OP_LOAD) begin
				if (quot_s1.in_range) begin
					for (int i = 0; i < 4; i++) begin
						digit_q[i] <= new_digit[i];
					end
				end
			end else if (do_scan) begin
				tick_count_q <= '0;
				scan_index_q <= idx + 2'd1;
				seg_latch_q  <= seg_next;
				sel_latch_q  <= sel_next;
			end else begin
				tick_count_q <= tick_next;
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			segments     <= seg_next;
			digit_select <= sel_next;
			scanned      <= do_scan;
		end
	end

	// ---------------- assertions ----------------
	a_scan_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scanned |-> $onehot(digit_select))
		else $error("scan result without a one-hot strobe");

	a_scan_lit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scanned |-> segments != 8'h00 && !segments[7])
		else $error("scanned digit shows no segments or a lit dp");

	a_sel_latch: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel_latch_q))
		else $error("strobe latch has more than one digit");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty result register");

endmodule

// ===== hdl/sssd_bcd_split.sv =====
// Decimal quotient stage: v/10, v/100, v/1000 of a load value by reciprocal multiply.
// Depends on sssd_pkg.
`timescale 1ns / 1ps

module sssd_bcd_split (
	input  logic [15:0]          value,
	output sssd_pkg::quot_t      quot
);

	logic [13:0] x;
	logic [29:0] p10;
	logic [26:0] p100;
	logic [27:0] p1000;

	// Only in-range values are used, and they fit in 14 bits
	assign x     = value[13:0];
	assign p10   = 30'(x) * 30'(sssd_pkg::RECIP10);
	assign p100  = 27'(x) * 27'(sssd_pkg::RECIP100);
	assign p1000 = 28'(x) * 28'(sssd_pkg::RECIP1000);

	assign quot.in_range = (value < sssd_pkg::LOAD_LIMIT);
	assign quot.q10      = p10[28:19];
	assign quot.q100     = p100[25:19];
	assign quot.q1000    = p1000[26:23];

endmodule
